@@ rtl/core/rgbhsl_pkg.sv @@
package rgbhsl_pkg;

    // Hue is carried in 1/64 degree units.
    localparam int HUE_BITS = 15;

    // Sixty degrees and one full turn in hue units.
    localparam int SIXTY_DEG = 3840;
    localparam int FULL_TURN = 23040;

    // Bits needed for the fractional hue quotient, which never exceeds SIXTY_DEG.
    localparam int HUE_QUO_BITS = 12;

    // Color sector picked by the largest component.
    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } sector_t;

endpackage

@@ rtl/core/rgbhsl_rgb_if.sv @@
interface rgbhsl_rgb_if #(
    parameter int COLOR_BITS = 8
);

    logic                  valid;
    logic                  ready;
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;

    modport source (
        output valid,
        output red,
        output green,
        output blue,
        input  ready
    );

    modport sink (
        input  valid,
        input  red,
        input  green,
        input  blue,
        output ready
    );

endinterface

@@ rtl/core/rgbhsl_hsl_if.sv @@
interface rgbhsl_hsl_if
    import rgbhsl_pkg::*;
#(
    parameter int COLOR_BITS = 8
);

    logic                  valid;
    logic                  ready;
    logic [HUE_BITS-1:0]   hue;
    logic [COLOR_BITS-1:0] saturation;
    logic [COLOR_BITS:0]   lightness;

    modport source (
        output valid,
        output hue,
        output saturation,
        output lightness,
        input  ready
    );

    modport sink (
        input  valid,
        input  hue,
        input  saturation,
        input  lightness,
        output ready
    );

endinterface

@@ rtl/core/rgb_to_hsl_converter.sv @@
// RGB to HSL pixel converter. Each request carries one pixel as red, green and blue
// of COLOR_BITS bits (all ones means 1.0) and yields one result: hue in 1/64 degree
// (0 to 23039), saturation scaled to all ones, and lightness as max plus min. The
// block accepts one pixel every clock unless the output stalls, and returns results
// in order. One stage finds max, min and the hue difference, one stage forms the
// dividends and the saturation divisor, then two restoring dividers, hue and
// saturation side by side, resolve one quotient bit per stage, and a last stage
// assembles the hue and drives the output register. Every stage holds its own valid
// bit, so bubbles close up while the output stalls.
module rgb_to_hsl_converter
    import rgbhsl_pkg::*;
#(
    parameter int COLOR_BITS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    rgbhsl_rgb_if.sink    rgb,
    rgbhsl_hsl_if.source  hsl
);

    localparam int CB   = COLOR_BITS;
    // Quotient bits resolved by the divider pipeline.
    localparam int QB   = (CB > HUE_QUO_BITS) ? CB : HUE_QUO_BITS;
    // Remainder width, wide enough for both dividends and shifted divisors.
    localparam int RW   = CB + QB;
    // Front stage, dividend stage, QB divider stages, output stage.
    localparam int NSTG = QB + 3;
    localparam int OUT  = NSTG - 1;

    localparam logic [CB-1:0] FULL = '1;

    typedef struct packed {
        sector_t       sect;
        logic          negf;
        logic [CB-1:0] mag;
        logic [CB-1:0] dlt;
        logic [CB:0]   sum;
    } front_t;

    typedef struct packed {
        logic [RW-1:0] rem_h;
        logic [RW-1:0] rem_s;
        logic [CB-1:0] dlt;
        logic [CB-1:0] den;
        logic [QB-1:0] q_h;
        logic [QB-1:0] q_s;
        sector_t       sect;
        logic          negf;
        logic          grey;
        logic [CB:0]   sum;
    } div_t;

    logic [NSTG-1:0]     vld_reg;
    logic [NSTG-1:0]     en;
    front_t              front_reg;
    front_t              front_next;
    div_t                div_reg [0:QB];
    div_t                div_next;
    logic [HUE_BITS-1:0] hue_reg;
    logic [HUE_BITS-1:0] hue_next;
    logic [CB-1:0]       sat_reg;
    logic [CB:0]         lit_reg;

    // A stage may load when it is empty or when its content moves on.
    always_comb
    begin
        en[OUT] = !vld_reg[OUT] || hsl.ready;
        for (int k = OUT - 1; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k + 1];
        end
    end

    assign rgb.ready = en[0];

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= rgb.valid;
            end
            for (int k = 1; k < NSTG; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k - 1];
                end
            end
        end
    end

    // Front stage: max, min, sector, signed hue difference, delta and sum.
    always_comb
    begin
        logic [CB-1:0] hi;
        logic [CB-1:0] lo;
        logic [CB-1:0] pos;
        logic [CB-1:0] neg;
        hi = rgb.red;
        lo = rgb.red;
        if (rgb.green > hi)
        begin
            hi = rgb.green;
        end
        if (rgb.blue > hi)
        begin
            hi = rgb.blue;
        end
        if (rgb.green < lo)
        begin
            lo = rgb.green;
        end
        if (rgb.blue < lo)
        begin
            lo = rgb.blue;
        end
        // The first component equal to the maximum picks the sector.
        if (rgb.red >= rgb.green && rgb.red >= rgb.blue)
        begin
            front_next.sect = SECT_RED;
            pos = rgb.green;
            neg = rgb.blue;
        end
        else if (rgb.green >= rgb.blue)
        begin
            front_next.sect = SECT_GREEN;
            pos = rgb.blue;
            neg = rgb.red;
        end
        else
        begin
            front_next.sect = SECT_BLUE;
            pos = rgb.red;
            neg = rgb.green;
        end
        front_next.negf = pos < neg;
        front_next.mag  = (pos >= neg) ? (pos - neg) : (neg - pos);
        front_next.dlt  = hi - lo;
        front_next.sum  = {1'b0, hi} + {1'b0, lo};
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            front_reg <= front_next;
        end
    end

    // Dividend stage: scaled hue difference, scaled delta and saturation divisor.
    always_comb
    begin
        logic [CB:0] twice_full;
        logic [CB:0] den_wide;
        twice_full = {FULL, 1'b0};
        den_wide   = (front_reg.sum >= {1'b0, FULL}) ? (twice_full - front_reg.sum)
                                                     : front_reg.sum;
        div_next.rem_h = RW'(front_reg.mag) * RW'(SIXTY_DEG);
        div_next.rem_s = (RW'(front_reg.dlt) << CB) - RW'(front_reg.dlt);
        div_next.dlt   = front_reg.dlt;
        div_next.den   = den_wide[CB-1:0];
        div_next.q_h   = '0;
        div_next.q_s   = '0;
        div_next.sect  = front_reg.sect;
        div_next.negf  = front_reg.negf;
        div_next.grey  = (front_reg.dlt == '0);
        div_next.sum   = front_reg.sum;
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            div_reg[0] <= div_next;
        end
    end

    // Divider stages: each resolves one quotient bit of both divisions.
    for (genvar j = 1; j <= QB; j++)
    begin : g_div
        localparam int BITP = QB - j;

        logic [RW:0] trial_h;
        logic [RW:0] trial_s;
        div_t        step;

        always_comb
        begin
            trial_h = {1'b0, div_reg[j-1].rem_h} - {1'b0, RW'(div_reg[j-1].dlt) << BITP};
            trial_s = {1'b0, div_reg[j-1].rem_s} - {1'b0, RW'(div_reg[j-1].den) << BITP};
            step    = div_reg[j-1];
            if (!trial_h[RW])
            begin
                step.rem_h     = trial_h[RW-1:0];
                step.q_h[BITP] = 1'b1;
            end
            if (!trial_s[RW])
            begin
                step.rem_s     = trial_s[RW-1:0];
                step.q_s[BITP] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[j + 1])
            begin
                div_reg[j] <= step;
            end
        end
    end

    // Output stage: sector offset plus or minus the fraction, wrapped into one turn.
    always_comb
    begin
        logic [HUE_BITS-1:0] frac;
        frac = HUE_BITS'(div_reg[QB].q_h);
        case (div_reg[QB].sect)
            SECT_RED:
            begin
                // A negative fraction that truncates to zero leaves the hue at zero.
                hue_next = (div_reg[QB].negf && frac != '0) ? (HUE_BITS'(FULL_TURN) - frac)
                                                            : frac;
            end
            SECT_GREEN:
            begin
                hue_next = div_reg[QB].negf ? (HUE_BITS'(2 * SIXTY_DEG) - frac)
                                            : (HUE_BITS'(2 * SIXTY_DEG) + frac);
            end
            SECT_BLUE:
            begin
                hue_next = div_reg[QB].negf ? (HUE_BITS'(4 * SIXTY_DEG) - frac)
                                            : (HUE_BITS'(4 * SIXTY_DEG) + frac);
            end
            default:
            begin
                hue_next = '0;
            end
        endcase
        if (div_reg[QB].grey)
        begin
            hue_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[OUT])
        begin
            hue_reg <= hue_next;
            sat_reg <= div_reg[QB].grey ? '0 : div_reg[QB].q_s[CB-1:0];
            lit_reg <= div_reg[QB].sum;
        end
    end

    assign hsl.valid      = vld_reg[OUT];
    assign hsl.hue        = hue_reg;
    assign hsl.saturation = sat_reg;
    assign hsl.lightness  = lit_reg;

`ifndef NO_ASSERTIONS
    // A finished hue division leaves a remainder below the divisor.
    a_hue_rem: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[QB + 1] && !div_reg[QB].grey |-> div_reg[QB].rem_h < RW'(div_reg[QB].dlt))
        else $error("hue remainder not below delta");

    // A finished saturation division leaves a remainder below the divisor.
    a_sat_rem: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[QB + 1] && !div_reg[QB].grey |-> div_reg[QB].rem_s < RW'(div_reg[QB].den))
        else $error("saturation remainder not below divisor");

    // The assembled hue always lies within one turn.
    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        hsl.valid |-> hsl.hue < HUE_BITS'(FULL_TURN))
        else $error("hue outside one turn");

    // Black and white pixels carry no saturation.
    a_bw_sat: assert property (@(posedge clk) disable iff (!rst_n)
        hsl.valid && (hsl.lightness == '0 || hsl.lightness == {FULL, 1'b0})
        |-> hsl.saturation == '0)
        else $error("black or white pixel with saturation");

    // A stalled output stage holds back the stage behind it.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[OUT] && !hsl.ready && vld_reg[OUT - 1] |-> !en[OUT - 1])
        else $error("stage advanced into a stalled output");
`endif

endmodule

@@ sim/hsl_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels of the converter, predicts the HSL result of every
// accepted pixel request and compares it with what comes out, in order.
module hsl_checker
    import rgbhsl_pkg::*;
#(
    parameter int COLOR_BITS = 8
) (
    input  logic  clk,
    input  logic  rst_n,
    rgbhsl_rgb_if rgb,
    rgbhsl_hsl_if hsl,
    output int    mismatches,
    output int    pending,
    output int    results
);

    localparam longint FULL = (64'd1 << COLOR_BITS) - 1;

    typedef struct packed {
        logic [HUE_BITS-1:0]   hue;
        logic [COLOR_BITS-1:0] saturation;
        logic [COLOR_BITS:0]   lightness;
    } hsl_pixel_t;

    // Results still owed by the block, oldest first.
    hsl_pixel_t hsl_expected[$];

    // Fixed-point RGB to HSL conversion of one pixel.
    function automatic hsl_pixel_t rgb_to_hsl_predict(
        input logic [COLOR_BITS-1:0] r,
        input logic [COLOR_BITS-1:0] g,
        input logic [COLOR_BITS-1:0] b
    );
        longint     hi;
        longint     lo;
        longint     delta;
        longint     sum;
        longint     spread;
        longint     denom;
        longint     sat;
        longint     pos;
        longint     neg;
        longint     part;
        longint     hue_val;
        sector_t    sector;
        hsl_pixel_t px;

        hi = longint'(r);
        lo = longint'(r);
        if (g > hi) hi = longint'(g);
        if (b > hi) hi = longint'(b);
        if (g < lo) lo = longint'(g);
        if (b < lo) lo = longint'(b);
        delta   = hi - lo;
        sum     = hi + lo;
        sat     = 0;
        hue_val = 0;

        // A grey pixel keeps hue and saturation at zero.
        if (delta != 0)
        begin
            // The first component equal to the maximum picks the sector.
            if (hi == r)
            begin
                sector = SECT_RED;
                pos    = longint'(g);
                neg    = longint'(b);
            end
            else if (hi == g)
            begin
                sector = SECT_GREEN;
                pos    = longint'(b);
                neg    = longint'(r);
            end
            else
            begin
                sector = SECT_BLUE;
                pos    = longint'(r);
                neg    = longint'(g);
            end

            // The quotient is truncated toward zero, so divide the magnitude.
            if (pos >= neg)
                part = ((pos - neg) * SIXTY_DEG) / delta;
            else
                part = -(((neg - pos) * SIXTY_DEG) / delta);

            case (sector)
                SECT_RED:   hue_val = part;
                SECT_GREEN: hue_val = 2 * SIXTY_DEG + part;
                default:    hue_val = 4 * SIXTY_DEG + part;
            endcase
            if (hue_val < 0)
                hue_val += FULL_TURN;

            spread = (sum >= FULL) ? (sum - FULL) : (FULL - sum);
            denom  = FULL - spread;
            if (denom != 0)
                sat = (delta * FULL) / denom;
            if (sat > FULL)
                sat = FULL;
        end

        px.hue        = hue_val[HUE_BITS-1:0];
        px.saturation = sat[COLOR_BITS-1:0];
        px.lightness  = sum[COLOR_BITS:0];
        return px;
    endfunction

    initial
    begin
        mismatches = 0;
        pending    = 0;
        results    = 0;
    end

    // Compare each result with the oldest prediction, then log new requests.
    always @(posedge clk)
    begin
        hsl_pixel_t got;
        hsl_pixel_t want;

        if (rst_n)
        begin
            if (hsl.valid && hsl.ready)
            begin
                got.hue        = hsl.hue;
                got.saturation = hsl.saturation;
                got.lightness  = hsl.lightness;
                results++;
                if (hsl_expected.size() == 0)
                begin
                    $error("result with no pixel waiting: hue %0d saturation %0d lightness %0d",
                           got.hue, got.saturation, got.lightness);
                    mismatches++;
                end
                else
                begin
                    want = hsl_expected.pop_front();
                    if (got.hue !== want.hue)
                    begin
                        $error("hue mismatch: expected %0d, got %0d", want.hue, got.hue);
                        mismatches++;
                    end
                    if (got.saturation !== want.saturation)
                    begin
                        $error("saturation mismatch: expected %0d, got %0d",
                               want.saturation, got.saturation);
                        mismatches++;
                    end
                    if (got.lightness !== want.lightness)
                    begin
                        $error("lightness mismatch: expected %0d, got %0d",
                               want.lightness, got.lightness);
                        mismatches++;
                    end
                end
            end

            if (rgb.valid && rgb.ready)
                hsl_expected.push_back(rgb_to_hsl_predict(rgb.red, rgb.green, rgb.blue));

            pending = hsl_expected.size();
        end
    end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

// Drives pixel requests into the converter with varying pacing on both sides
// and reports the verdict from the checker's mismatch count.
module tb;

    import rgbhsl_pkg::*;

    localparam int COLOR_BITS    = 8;
    localparam int LATENCY       = 15;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_PIXELS  = 100;
    localparam int PHASES        = 5;

    logic clk;
    logic rst_n;

    int src_idle_pct;
    int sink_stall_pct;
    int mismatches;
    int pending;
    int results;
    int quiet_cycles = 0;
    int directed_pixels = 0;
    int random_pixels = 0;

    // Pacing per phase: none, sender idle, receiver stalling, both, none.
    int phase_src_pct[PHASES]  = '{0, 77, 0, 33, 0};
    int phase_sink_pct[PHASES] = '{0, 0, 77, 33, 0};

    rgbhsl_rgb_if #(.COLOR_BITS(COLOR_BITS)) rgb_ch ();
    rgbhsl_hsl_if #(.COLOR_BITS(COLOR_BITS)) hsl_ch ();

    rgb_to_hsl_converter #(
        .COLOR_BITS(COLOR_BITS)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .rgb   (rgb_ch),
        .hsl   (hsl_ch)
    );

    hsl_checker #(
        .COLOR_BITS(COLOR_BITS)
    ) u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .rgb        (rgb_ch),
        .hsl        (hsl_ch),
        .mismatches (mismatches),
        .pending    (pending),
        .results    (results)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Receiver side: ready is redrawn at every falling edge.
    initial
    begin
        hsl_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            hsl_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Watchdog: too long without any request or result moving ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((rgb_ch.valid && rgb_ch.ready) || (hsl_ch.valid && hsl_ch.ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT)
                begin
                    $display("Watchdog expired with %0d results outstanding.", pending);
                    $display("[FAIL] regression broken");
                    $finish;
                end
            end
        end
    end

    // Present one pixel request at a falling edge and hold it until accepted.
    task automatic send_pixel(
        input logic [COLOR_BITS-1:0] r,
        input logic [COLOR_BITS-1:0] g,
        input logic [COLOR_BITS-1:0] b
    );
        while ($urandom_range(99) < src_idle_pct)
        begin
            rgb_ch.valid <= 1'b0;
            @(negedge clk);
        end
        rgb_ch.valid <= 1'b1;
        rgb_ch.red   <= r;
        rgb_ch.green <= g;
        rgb_ch.blue  <= b;
        @(posedge clk);
        while (!rgb_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_directed(
        input logic [COLOR_BITS-1:0] r,
        input logic [COLOR_BITS-1:0] g,
        input logic [COLOR_BITS-1:0] b
    );
        send_pixel(r, g, b);
        directed_pixels++;
    endtask

    // Random pixel, biased toward greys, tied maxima and extreme values.
    task automatic send_random_pixel();
        logic [COLOR_BITS-1:0] v[3];
        logic [COLOR_BITS-1:0] hi;
        logic [COLOR_BITS-1:0] lo;
        int                    kind;
        int                    odd;

        kind = $urandom_range(9);
        case (kind)
            0:
            begin
                v[0] = COLOR_BITS'($urandom_range(255));
                v[1] = v[0];
                v[2] = v[0];
            end
            1, 2:
            begin
                hi   = COLOR_BITS'($urandom_range(255));
                lo   = COLOR_BITS'($urandom_range(hi));
                odd  = $urandom_range(2);
                v[0] = (odd == 0) ? lo : hi;
                v[1] = (odd == 1) ? lo : hi;
                v[2] = (odd == 2) ? lo : hi;
            end
            3:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    case ($urandom_range(3))
                        0:       v[i] = 8'd0;
                        1:       v[i] = 8'd1;
                        2:       v[i] = 8'd254;
                        default: v[i] = 8'd255;
                    endcase
                end
            end
            default:
            begin
                v[0] = COLOR_BITS'($urandom_range(255));
                v[1] = COLOR_BITS'($urandom_range(255));
                v[2] = COLOR_BITS'($urandom_range(255));
            end
        endcase
        send_pixel(v[0], v[1], v[2]);
        random_pixels++;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        rgb_ch.valid   = 1'b0;
        rgb_ch.red     = '0;
        rgb_ch.green   = '0;
        rgb_ch.blue    = '0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Corner pixels: black, white, greys, primaries, ties and hue wrap.
        send_directed(8'd0,   8'd0,   8'd0);
        send_directed(8'd255, 8'd255, 8'd255);
        send_directed(8'd128, 8'd128, 8'd128);
        send_directed(8'd255, 8'd0,   8'd0);
        send_directed(8'd0,   8'd255, 8'd0);
        send_directed(8'd0,   8'd0,   8'd255);
        send_directed(8'd255, 8'd255, 8'd0);
        send_directed(8'd0,   8'd255, 8'd255);
        send_directed(8'd255, 8'd0,   8'd255);
        send_directed(8'd255, 8'd0,   8'd1);
        send_directed(8'd200, 8'd100, 8'd150);
        send_directed(8'd1,   8'd255, 8'd0);
        send_directed(8'd0,   8'd1,   8'd255);
        send_directed(8'd1,   8'd0,   8'd0);
        send_directed(8'd255, 8'd254, 8'd254);
        send_directed(8'd127, 8'd128, 8'd0);
        send_directed(8'd170, 8'd85,  8'd0);
        send_directed(8'd85,  8'd170, 8'd255);

        // Random pixels under each pacing phase in turn.
        for (int p = 0; p < PHASES; p++)
        begin
            src_idle_pct   = phase_src_pct[p];
            sink_stall_pct = phase_sink_pct[p];
            repeat (PHASE_PIXELS) send_random_pixel();
        end
        rgb_ch.valid <= 1'b0;

        // Drain, then give a stray late result time to show up.
        while (pending != 0)
            @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);

        $display("Converted %0d pixels: %0d corner cases and %0d random under five pacing phases.",
                 results, directed_pixels, random_pixels);
        $display("Random mix included greys, tied maxima and extreme component values.");
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
